// ----- sv/assert_macros.svh -----
// Assertion helper macros used by tilt_compensated_heading.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- sv/tch_pkg.sv -----
// ----------------------------------------------------------------------------
// tch_pkg
// Constants, formats and helper functions for the tilt-compensated heading.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package tch_pkg;

  localparam int unsigned CordicSteps  = 16;
  localparam int unsigned FractionBits = 16;
  localparam int unsigned TableLen     = 24;
  localparam int unsigned NumSteps     = (CordicSteps < TableLen) ? CordicSteps : TableLen;

  // Datapath widths: sin/cos values are below 2 in QF, heading vector below 2^35.
  localparam int unsigned ScW  = FractionBits + 3;
  localparam int unsigned ZW   = FractionBits + 4;
  localparam int unsigned VecW = FractionBits + 21;

  localparam longint GainQ30    = 64'd652032874;
  localparam longint PiQ30      = 64'd3373259426;
  localparam longint CdegRadQ30 = 64'd187403;
  localparam longint RadCdegQ16 = 64'd375493621;

  typedef logic signed [ScW-1:0]  sc_t;
  typedef logic signed [ZW-1:0]   ang_t;
  typedef logic signed [VecW-1:0] vec_t;

  // Rotation-cell state.
  typedef struct packed {
    sc_t  x;
    sc_t  y;
    ang_t z;
  } rot_t;

  // Vectoring-cell state.
  typedef struct packed {
    vec_t x;
    vec_t y;
    ang_t z;
    logic zero;
  } vct_t;

  // Round a Q30 constant to QF, half up.
  function automatic longint to_qf(input longint q30);
    to_qf = (q30 + (64'sd1 <<< (30 - FractionBits - 1))) >>> (30 - FractionBits);
  endfunction

  function automatic longint atan_q30(input int unsigned i);
    case (i)
      0: atan_q30 = 843314857;   1: atan_q30 = 497837829;
      2: atan_q30 = 263043837;   3: atan_q30 = 133525159;
      4: atan_q30 = 67021687;    5: atan_q30 = 33543516;
      6: atan_q30 = 16775851;    7: atan_q30 = 8388438;
      8: atan_q30 = 4194283;     9: atan_q30 = 2097151;
      10: atan_q30 = 1048576;    11: atan_q30 = 524288;
      12: atan_q30 = 262144;     13: atan_q30 = 131072;
      14: atan_q30 = 65536;      15: atan_q30 = 32768;
      16: atan_q30 = 16384;      17: atan_q30 = 8192;
      18: atan_q30 = 4096;       19: atan_q30 = 2048;
      20: atan_q30 = 1024;       21: atan_q30 = 512;
      22: atan_q30 = 256;        default: atan_q30 = 128;
    endcase
  endfunction

  function automatic ang_t atan_qf(input int unsigned i);
    atan_qf = ang_t'(to_qf(atan_q30(i)));
  endfunction

endpackage
`default_nettype wire

// ----- sv/tch_if.sv -----
// ----------------------------------------------------------------------------
// tch_sample_if / tch_heading_if
// Valid/ready channels for magnetometer samples and headings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface tch_sample_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] mag_x;
  logic signed [15:0] mag_y;
  logic signed [15:0] mag_z;
  logic signed [15:0] roll_angle;
  logic signed [15:0] pitch_angle;
  modport source (output valid, mag_x, mag_y, mag_z, roll_angle, pitch_angle,
                  input ready);
  modport sink (input valid, mag_x, mag_y, mag_z, roll_angle, pitch_angle,
                output ready);
endinterface

interface tch_heading_if;
  logic        valid;
  logic        ready;
  logic [15:0] heading;
  modport source (output valid, heading, input ready);
  modport sink (input valid, heading, output ready);
endinterface
`default_nettype wire

// ----- sv/tch_rot_cell.sv -----
// ----------------------------------------------------------------------------
// tch_rot_cell
// One rotation-mode micro-rotation; index selected by a port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tch_rot_cell (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [4:0]    idx_i,
  input  tch_pkg::rot_t      a_i,
  output tch_pkg::rot_t      a_o
);
  import tch_pkg::*;

  rot_t r_d, r_q;
  ang_t ang;

  // Rotate toward zero residual angle.
  always_comb begin
    ang = atan_qf(32'(idx_i));
    if (a_i.z >= 0) begin
      r_d.x = a_i.x - (a_i.y >>> idx_i);
      r_d.y = a_i.y + (a_i.x >>> idx_i);
      r_d.z = a_i.z - ang;
    end else begin
      r_d.x = a_i.x + (a_i.y >>> idx_i);
      r_d.y = a_i.y - (a_i.x >>> idx_i);
      r_d.z = a_i.z + ang;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q <= r_d;
    end
  end

  assign a_o = r_q;
endmodule
`default_nettype wire

// ----- sv/tch_vec_cell.sv -----
// ----------------------------------------------------------------------------
// tch_vec_cell
// One vectoring-mode micro-rotation driving y toward zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tch_vec_cell (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [4:0]    idx_i,
  input  tch_pkg::vct_t      a_i,
  output tch_pkg::vct_t      a_o
);
  import tch_pkg::*;

  vct_t r_d, r_q;
  ang_t ang;

  always_comb begin
    ang    = atan_qf(32'(idx_i));
    r_d    = a_i;
    if (a_i.y > 0) begin
      r_d.x = a_i.x + (a_i.y >>> idx_i);
      r_d.y = a_i.y - (a_i.x >>> idx_i);
      r_d.z = a_i.z + ang;
    end else begin
      r_d.x = a_i.x - (a_i.y >>> idx_i);
      r_d.y = a_i.y + (a_i.x >>> idx_i);
      r_d.z = a_i.z - ang;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q <= r_d;
    end
  end

  assign a_o = r_q;
endmodule
`default_nettype wire

// ----- sv/tilt_compensated_heading.sv -----
// ----------------------------------------------------------------------------
// tilt_compensated_heading
// Tilt-compensated compass heading through two chains of CORDIC cells.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload
// smp_i    in   mag_x, mag_y, mag_z, roll_angle, pitch_angle
// hdg_o    out  heading (0..35999 hundredths of a degree)
//
// One sample per cycle while hdg_o is not stalled; the pipeline holds two input
// stages, the rotation chain, four product stages, the vectoring chain and
// two output stages.
// The whole pipeline advances only while the output register can move,
// so a stall on hdg_o holds every stage. Reset clears the valid bits only.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module tilt_compensated_heading (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  tch_sample_if.sink     smp_i,
  tch_heading_if.source  hdg_o
);
  import tch_pkg::*;

  localparam int unsigned Pre  = 2;           // reduce, scale
  localparam int unsigned Mid  = 4;           // products, sums, fold
  localparam int unsigned Post = 2;           // scale, wrap
  localparam int unsigned Lat  = Pre + NumSteps + Mid + NumSteps + Post;

  logic           adv;
  logic [Lat-1:0] vld_q;

  assign adv         = !hdg_o.valid || hdg_o.ready;
  assign smp_i.ready = adv;

  // Advance valid bits with the pipeline.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Lat-2:0], smp_i.valid};
    end
  end
  assign hdg_o.valid = vld_q[Lat-1];

  // ---- Stage 1: reduce angles into -9000..9000 ----
  typedef struct packed {
    logic signed [15:0] r;
    logic               neg;
  } red_t;

  function automatic red_t reduce(input logic signed [15:0] a);
    logic signed [17:0] r;
    red_t o;
    r = 18'(a);
    if (r >= 18000) r = 18'(r - 36000);
    else if (r < -18000) r = 18'(r + 36000);
    o.neg = 1'b0;
    if (r > 9000) begin
      r = 18'(18000 - r); o.neg = 1'b1;
    end else if (r < -9000) begin
      r = 18'(-18000 - r); o.neg = 1'b1;
    end
    o.r = r[15:0];
    return o;
  endfunction

  red_t               rr_d, pr_d;
  red_t               rr_q, pr_q;
  logic signed [15:0] mx_q [Pre];
  logic signed [15:0] my_q [Pre];
  logic signed [15:0] mz_q [Pre];
  logic               rn_q [Pre];
  logic               pn_q [Pre];

  assign rr_d = reduce(smp_i.roll_angle);
  assign pr_d = reduce(smp_i.pitch_angle);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rr_q     <= rr_d;
      pr_q     <= pr_d;
      mx_q[0]  <= smp_i.mag_x;
      my_q[0]  <= smp_i.mag_y;
      mz_q[0]  <= smp_i.mag_z;
      rn_q[0]  <= rr_d.neg;
      pn_q[0]  <= pr_d.neg;
      mx_q[1]  <= mx_q[0];
      my_q[1]  <= my_q[0];
      mz_q[1]  <= mz_q[0];
      rn_q[1]  <= rn_q[0];
      pn_q[1]  <= pn_q[0];
    end
  end

  // ---- Stage 2: degrees to radians, seed rotation chains ----
  rot_t rs_q, ps_q;
  localparam longint RadHalf = 64'sd1 <<< (30 - FractionBits - 1);

  function automatic ang_t to_rad(input logic signed [15:0] c);
    logic signed [40:0] p;
    p = 41'(c) * 41'(CdegRadQ30) + 41'(RadHalf);
    return ang_t'(p >>> (30 - FractionBits));
  endfunction

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rs_q.x <= sc_t'(to_qf(GainQ30));
      rs_q.y <= '0;
      rs_q.z <= to_rad(rr_q.r);
      ps_q.x <= sc_t'(to_qf(GainQ30));
      ps_q.y <= '0;
      ps_q.z <= to_rad(pr_q.r);
    end
  end

  // ---- Rotation chains: roll and pitch side by side ----
  rot_t rch [NumSteps+1];
  rot_t pch [NumSteps+1];
  logic signed [15:0] cmx_q [NumSteps];
  logic signed [15:0] cmy_q [NumSteps];
  logic signed [15:0] cmz_q [NumSteps];
  logic               crn_q [NumSteps];
  logic               cpn_q [NumSteps];

  assign rch[0] = rs_q;
  assign pch[0] = ps_q;

  for (genvar g = 0; g < NumSteps; g++) begin : g_rot
    tch_rot_cell u_rcell (.clk_i, .en_i(adv), .idx_i(5'(g)), .a_i(rch[g]), .a_o(rch[g+1]));
    tch_rot_cell u_pcell (.clk_i, .en_i(adv), .idx_i(5'(g)), .a_i(pch[g]), .a_o(pch[g+1]));
    always_ff @(posedge clk_i) begin
      if (adv) begin
        cmx_q[g] <= (g == 0) ? mx_q[Pre-1] : cmx_q[(g == 0) ? 0 : g-1];
        cmy_q[g] <= (g == 0) ? my_q[Pre-1] : cmy_q[(g == 0) ? 0 : g-1];
        cmz_q[g] <= (g == 0) ? mz_q[Pre-1] : cmz_q[(g == 0) ? 0 : g-1];
        crn_q[g] <= (g == 0) ? rn_q[Pre-1] : crn_q[(g == 0) ? 0 : g-1];
        cpn_q[g] <= (g == 0) ? pn_q[Pre-1] : cpn_q[(g == 0) ? 0 : g-1];
      end
    end
  end

  // ---- Product stages ----
  localparam int unsigned PW = 2 * ScW;
  sc_t sr, cr, sp, cp;
  assign sr = rch[NumSteps].y;
  assign sp = pch[NumSteps].y;
  assign cr = crn_q[NumSteps-1] ? -rch[NumSteps].x : rch[NumSteps].x;
  assign cp = cpn_q[NumSteps-1] ? -pch[NumSteps].x : pch[NumSteps].x;

  // M1: sin products rounded to QF, cos/sin carried
  sc_t srsp_q, srcp_q, m1cr_q, m1sp_q, m1cp_q;
  logic signed [15:0] m1x_q, m1y_q, m1z_q;
  logic signed [PW-1:0] psp, pcp;
  assign psp = PW'(sr) * PW'(sp) + (PW'(1) <<< (FractionBits - 1));
  assign pcp = PW'(sr) * PW'(cp) + (PW'(1) <<< (FractionBits - 1));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      srsp_q <= sc_t'(psp >>> FractionBits);
      srcp_q <= sc_t'(pcp >>> FractionBits);
      m1cr_q <= cr;
      m1sp_q <= sp;
      m1cp_q <= cp;
      m1x_q  <= cmx_q[NumSteps-1];
      m1y_q  <= cmy_q[NumSteps-1];
      m1z_q  <= cmz_q[NumSteps-1];
    end
  end

  // M2: field products
  vec_t p_xcp_q, p_zsp_q, p_xss_q, p_ycr_q, p_zsc_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_xcp_q <= VecW'(m1x_q) * VecW'(m1cp_q);
      p_zsp_q <= VecW'(m1z_q) * VecW'(m1sp_q);
      p_xss_q <= VecW'(m1x_q) * VecW'(srsp_q);
      p_ycr_q <= VecW'(m1y_q) * VecW'(m1cr_q);
      p_zsc_q <= VecW'(m1z_q) * VecW'(srcp_q);
    end
  end

  // M3: horizontal components
  vec_t xh_q, yh_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      xh_q <= p_xcp_q + p_zsp_q;
      yh_q <= p_xss_q + p_ycr_q - p_zsc_q;
    end
  end

  // M4: fold left half plane, seed vectoring chain
  vct_t vs_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      vs_q.zero <= (xh_q == '0) && (yh_q == '0);
      if (xh_q < 0) begin
        vs_q.x <= -xh_q;
        vs_q.y <= -yh_q;
        vs_q.z <= ang_t'(to_qf(PiQ30));
      end else begin
        vs_q.x <= xh_q;
        vs_q.y <= yh_q;
        vs_q.z <= '0;
      end
    end
  end

  // ---- Vectoring chain ----
  vct_t vch [NumSteps+1];
  assign vch[0] = vs_q;
  for (genvar g = 0; g < NumSteps; g++) begin : g_vec
    tch_vec_cell u_vcell (.clk_i, .en_i(adv), .idx_i(5'(g)), .a_i(vch[g]), .a_o(vch[g+1]));
  end

  // ---- Post: radians to hundredths, then wrap ----
  localparam int unsigned HW = ZW + 30;
  logic signed [HW-1:0] hp;
  logic signed [19:0]   h_q;
  logic                 hz_q;
  logic signed [19:0]   hw;
  logic [15:0]          heading_q;

  assign hp = HW'(vch[NumSteps].z) * HW'(RadCdegQ16)
            + (HW'(1) <<< (FractionBits + 15));

  always_ff @(posedge clk_i) begin
    if (adv) begin
      h_q  <= 20'(hp >>> (FractionBits + 16));
      hz_q <= vch[NumSteps].zero;
    end
  end

  // Heading stays within one turn either side, one correction suffices.
  always_comb begin
    hw = h_q;
    if (hw >= 36000) hw = 20'(hw - 36000);
    else if (hw < 0) hw = 20'(hw + 36000);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      heading_q <= hz_q ? 16'd0 : hw[15:0];
    end
  end
  assign hdg_o.heading = heading_q;

  `ASSERT_IMPL(a_ready_adv, clk_i, rst_ni, hdg_o.valid && !hdg_o.ready, !smp_i.ready, "input taken during stall")
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, hdg_o.valid && !hdg_o.ready, hdg_o.valid && $stable(hdg_o.heading), "stalled heading moved")
  `ASSERT_IMPL(a_range, clk_i, rst_ni, hdg_o.valid, hdg_o.heading < 16'd36000, "heading out of range")

endmodule
`default_nettype wire

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tilt-compensated heading: directed table, then
// random samples, each heading compared against a known value or a bit-exact CORDIC predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
  import tch_pkg::*;

  logic clk_i;
  logic rst_ni;
  longint cycle_cnt;
  int     err_cnt;

  tch_sample_if  smp_if ();
  tch_heading_if hdg_if ();

  tilt_compensated_heading i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .smp_i  (smp_if.sink),
    .hdg_o  (hdg_if.source)
  );

  typedef struct {
    logic signed [15:0] mx;
    logic signed [15:0] my;
    logic signed [15:0] mz;
    logic signed [15:0] roll;
    logic signed [15:0] pitch;
    int                 known;
  } sample_t;

  logic [15:0] heading_q[$];
  sample_t     table_q[$];

  localparam int MaxCycles = 400000;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Stop on runaway
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MaxCycles) begin
      $display("tilt_compensated_heading test failed");
      $finish;
    end
  end

  function automatic longint fshift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rshift(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint qf_of(longint q30);
    return rshift(q30, 30 - FractionBits);
  endfunction

  // Rotate by an angle in hundredths of a degree; returns sin and cos in QF
  function automatic void rotate_angle(input int cdeg, output longint s,
                                       output longint c);
    int     r;
    bit     flip;
    longint x, y, z, t, a;
    r = cdeg % 36000;
    flip = 0;
    if (r < 0) r += 36000;
    if (r >= 18000) r -= 36000;
    if (r > 9000) begin
      r = 18000 - r;
      flip = 1;
    end else if (r < -9000) begin
      r = -18000 - r;
      flip = 1;
    end
    z = rshift(longint'(r) * CdegRadQ30, 30 - FractionBits);
    x = qf_of(GainQ30);
    y = 0;
    for (int i = 0; i < NumSteps; i++) begin
      a = qf_of(atan_q30(i));
      if (z >= 0) begin
        t = x - fshift(y, i);
        y = y + fshift(x, i);
        z -= a;
      end else begin
        t = x + fshift(y, i);
        y = y - fshift(x, i);
        z += a;
      end
      x = t;
    end
    s = y;
    c = flip ? -x : x;
  endfunction

  function automatic logic [15:0] predict_heading(sample_t smp);
    longint sr, cr, sp, cp, srsp, srcp, xh, yh, z, h, t, a;
    rotate_angle(int'(smp.roll), sr, cr);
    rotate_angle(int'(smp.pitch), sp, cp);
    srsp = rshift(sr * sp, FractionBits);
    srcp = rshift(sr * cp, FractionBits);
    xh = longint'(smp.mx) * cp + longint'(smp.mz) * sp;
    yh = longint'(smp.mx) * srsp + longint'(smp.my) * cr - longint'(smp.mz) * srcp;
    if (xh == 0 && yh == 0) return 16'd0;
    z = 0;
    if (xh < 0) begin
      xh = -xh;
      yh = -yh;
      z = qf_of(PiQ30);
    end
    for (int i = 0; i < NumSteps; i++) begin
      a = qf_of(atan_q30(i));
      if (yh > 0) begin
        t = xh + fshift(yh, i);
        yh = yh - fshift(xh, i);
        z += a;
      end else begin
        t = xh - fshift(yh, i);
        yh = yh + fshift(xh, i);
        z -= a;
      end
      xh = t;
    end
    h = rshift(z * RadCdegQ16, FractionBits + 16);
    h = h % 36000;
    if (h < 0) h += 36000;
    return h[15:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
             cycle_cnt);
    err_cnt++;
  endtask

  function automatic bit idle_now();
    return (cycle_cnt % 4000) >= 1000 && $urandom_range(99) < 28;
  endfunction

  // Check each heading transaction against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && hdg_if.valid && hdg_if.ready) begin
      if (heading_q.size() == 0) begin
        report_mismatch("unexpected heading", hdg_if.heading, 16'd0);
      end else begin
        if (hdg_if.heading !== heading_q[0])
          report_mismatch("heading", hdg_if.heading, heading_q[0]);
        void'(heading_q.pop_front());
      end
    end
  end

  // Sink stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdg_if.ready <= 1'b0;
    end else begin
      hdg_if.ready <= !idle_now();
    end
  end

  function automatic sample_t mk(int mx, int my, int mz, int r, int p, int k);
    sample_t s;
    s.mx = 16'(mx); s.my = 16'(my); s.mz = 16'(mz);
    s.roll = 16'(r); s.pitch = 16'(p); s.known = k;
    return s;
  endfunction

  function automatic int rnd_angle();
    case ($urandom_range(9))
      0: return int'($urandom_range(65535)) - 32768;
      1: return int'($urandom_range(8)) * 4500 - 18000;
      default: return int'($urandom_range(36000)) - 18000;
    endcase
  endfunction

  function automatic int rnd_axis();
    case ($urandom_range(7))
      0: return $urandom_range(1) ? 32767 : -32768;
      1: return int'($urandom_range(20)) - 10;
      default: return int'($urandom_range(65535)) - 32768;
    endcase
  endfunction

  // Stimulus
  initial begin
    sample_t smp;
    int      idx;
    cycle_cnt = 0;
    err_cnt = 0;
    rst_ni = 1'b0;
    smp_if.valid = 1'b0;
    smp_if.mag_x = '0;
    smp_if.mag_y = '0;
    smp_if.mag_z = '0;
    smp_if.roll_angle = '0;
    smp_if.pitch_angle = '0;
    // Directed rows; known = -1 means use the predictor
    table_q.push_back(mk(0, 0, 0, 0, 0, 0));              // vector at zero
    table_q.push_back(mk(0, 0, 0, 9000, -9000, 0));
    table_q.push_back(mk(1000, 0, 0, 0, 0, -1));          // due north
    table_q.push_back(mk(32767, 32767, 32767, 0, 0, -1));
    table_q.push_back(mk(-32768, -32768, -32768, 0, 0, -1));
    table_q.push_back(mk(0, 1000, 0, 0, 0, -1));
    table_q.push_back(mk(0, -1000, 0, 0, 0, -1));
    table_q.push_back(mk(-1000, 0, 0, 0, 0, -1));         // left half plane
    table_q.push_back(mk(-1000, 1, 0, 0, 0, -1));
    table_q.push_back(mk(-1000, -1, 0, 0, 0, -1));        // left half plane, negative y
    table_q.push_back(mk(1000, -1, 0, 0, 0, -1));
    table_q.push_back(mk(500, 300, 200, 18000, 18000, -1));
    table_q.push_back(mk(500, 300, 200, -18000, -18000, -1));
    table_q.push_back(mk(500, 300, 200, 9000, 9000, -1));
    table_q.push_back(mk(500, 300, 200, -9000, -9000, -1));
    table_q.push_back(mk(500, 300, 200, 32767, -32768, -1)); // out of range
    table_q.push_back(mk(500, 300, 200, -32768, 32767, -1));
    table_q.push_back(mk(500, 300, 200, 9001, -9001, -1));
    table_q.push_back(mk(-700, 900, -1200, 4500, 3000, -1));
    table_q.push_back(mk(12345, -23456, 7890, -1234, 17999, -1));
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idx = 0;
    while (idx < 1800 + table_q.size()) begin
      if (idx < table_q.size()) smp = table_q[idx];
      else smp = mk(rnd_axis(), rnd_axis(), rnd_axis(), rnd_angle(), rnd_angle(), -1);
      if (idle_now()) begin
        smp_if.valid <= 1'b0;
        @(posedge clk_i);
      end
      smp_if.valid <= 1'b1;
      smp_if.mag_x <= smp.mx;
      smp_if.mag_y <= smp.my;
      smp_if.mag_z <= smp.mz;
      smp_if.roll_angle <= smp.roll;
      smp_if.pitch_angle <= smp.pitch;
      @(posedge clk_i);
      while (!smp_if.ready) @(posedge clk_i);
      heading_q.push_back(smp.known >= 0 ? 16'(smp.known) : predict_heading(smp));
      idx++;
    end
    smp_if.valid <= 1'b0;
    while (heading_q.size() != 0) @(posedge clk_i);
    repeat (2 * CordicSteps + 20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("tilt_compensated_heading test passed");
    end else begin
      $display("tilt_compensated_heading test failed");
    end
    $finish;
  end
endmodule
